// File: hw/rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants of the four-function calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffc_pkg;

  localparam int ModeW  = 2;
  localparam int KeyW   = 8;
  localparam int PhaseW = 2;
  localparam int ResW   = 32;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [PhaseW-1:0] {
    PH_FIRST,
    PH_OPER,
    PH_SECOND,
    PH_RESULT
  } phase_t;

  localparam logic [ModeW-1:0] MODE_KEY = 2'd0;
  localparam logic [ModeW-1:0] MODE_INC = 2'd1;
  localparam logic [ModeW-1:0] MODE_DEC = 2'd2;

  localparam logic [KeyW-1:0] KEY_CLEAR = 8'h43;  // 'C'
  localparam logic [KeyW-1:0] KEY_PLUS  = 8'h2B;  // '+'
  localparam logic [KeyW-1:0] KEY_MINUS = 8'h2D;  // '-'
  localparam logic [KeyW-1:0] KEY_STAR  = 8'h2A;  // '*'
  localparam logic [KeyW-1:0] KEY_SLASH = 8'h2F;  // '/'
  localparam logic [KeyW-1:0] KEY_EQUAL = 8'h3D;  // '='
  localparam logic [KeyW-1:0] KEY_ZERO  = 8'h30;  // '0'
  localparam logic [KeyW-1:0] KEY_NINE  = 8'h39;  // '9'

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic start_arith;
    logic commit;
  } ffc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_arith;
    logic arith_done;
    logic out_free;
  } ffc_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ffc_if.sv
// ----------------------------------------------------------------------------
// ffc_if
// Valid/ready channels of the calculator: key input and display result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ffc_pkg::ModeW-1:0]  mode;
  logic [ffc_pkg::KeyW-1:0]   key_code;

  modport source (output valid, output mode, output key_code, input ready);
  modport sink   (input valid, input mode, input key_code, output ready);
endinterface

interface ffc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             display_clear;
  logic                             echo_valid;
  logic [ffc_pkg::KeyW-1:0]         echo_char;
  logic                             result_valid;
  logic signed [ffc_pkg::ResW-1:0]  result_value;
  logic [ffc_pkg::PhaseW-1:0]       phase;
  logic                             divide_by_zero;

  modport source (output valid, output display_clear, output echo_valid, output echo_char,
                  output result_valid, output result_value, output phase,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input display_clear, input echo_valid, input echo_char,
                  input result_valid, input result_value, input phase,
                  input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ffc_alu.sv
// ----------------------------------------------------------------------------
// ffc_alu
// Arithmetic unit: add/sub in one step, shift-add multiply and restoring
// signed divide at one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_alu #(
  parameter int W = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ffc_pkg::op_t  op,
  input  wire logic [W-1:0]  a,
  input  wire logic [W-1:0]  b,
  output logic               done,
  output logic [W-1:0]       res,
  output logic               dz
);
  import ffc_pkg::*;

  localparam int CntW = $clog2(W + 1);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_NEG,
    U_FIN
  } ustate_t;

  ustate_t         ust_r, ust_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    x_r, x_nxt;     // multiplicand, or dividend shifting into quotient
  logic [W-1:0]    y_r, y_nxt;     // multiplier, or divisor magnitude
  logic [W-1:0]    rem_r, rem_nxt;
  logic            neg_r, neg_nxt;
  logic            dz_r, dz_nxt;
  logic [W:0]      trial;

  always_comb begin
    ust_nxt = ust_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    dz_nxt  = dz_r;
    trial   = {rem_r, x_r[W-1]} - {1'b0, y_r};
    case (ust_r)
      U_IDLE: begin
        if (start) begin
          dz_nxt = 1'b0;
          case (op)
            OP_ADD: begin
              acc_nxt = a + b;
              ust_nxt = U_FIN;
            end
            OP_SUB: begin
              acc_nxt = a - b;
              ust_nxt = U_FIN;
            end
            OP_MUL: begin
              acc_nxt = '0;
              x_nxt   = a;
              y_nxt   = b;
              cnt_nxt = CntW'(W);
              ust_nxt = U_MUL;
            end
            default: begin
              if (b == '0) begin
                acc_nxt = '0;
                dz_nxt  = 1'b1;
                ust_nxt = U_FIN;
              end else begin
                x_nxt   = a[W-1] ? (~a + W'(1)) : a;
                y_nxt   = b[W-1] ? (~b + W'(1)) : b;
                rem_nxt = '0;
                neg_nxt = a[W-1] ^ b[W-1];
                cnt_nxt = CntW'(W);
                ust_nxt = U_DIV;
              end
            end
          endcase
        end
      end
      U_MUL: begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt   = {x_r[W-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[W-1:1]};
        cnt_nxt = cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          ust_nxt = U_FIN;
        end
      end
      U_DIV: begin
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0];
          x_nxt   = {x_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[W-2:0], x_r[W-1]};
          x_nxt   = {x_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          ust_nxt = U_NEG;
        end
      end
      U_NEG: begin
        // most negative / -1 wraps back to most negative here
        acc_nxt = neg_r ? (~x_r + W'(1)) : x_r;
        ust_nxt = U_FIN;
      end
      U_FIN: begin
        ust_nxt = U_IDLE;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r <= U_IDLE;
    end else begin
      ust_r <= ust_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  assign done = (ust_r == U_FIN);
  assign res  = acc_r;
  assign dz   = dz_r;

endmodule

`default_nettype wire

// File: hw/rtl/ffc_dp.sv
// ----------------------------------------------------------------------------
// ffc_dp
// Calculator datapath: key decode, operand/result registers, arithmetic
// unit and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_dp #(
  parameter int W = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ffc_pkg::ffc_cmd_t           cmd,
  output ffc_pkg::ffc_stat_t               stat,
  input  wire logic [ffc_pkg::ModeW-1:0]   in_mode,
  input  wire logic [ffc_pkg::KeyW-1:0]    in_key,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_display_clear,
  output logic                             out_echo_valid,
  output logic [ffc_pkg::KeyW-1:0]         out_echo_char,
  output logic                             out_result_valid,
  output logic signed [ffc_pkg::ResW-1:0]  out_result_value,
  output logic [ffc_pkg::PhaseW-1:0]       out_phase,
  output logic                             out_divide_by_zero
);
  import ffc_pkg::*;

  typedef enum logic [2:0] {
    A_NONE,
    A_CLEAR,
    A_SETOP,
    A_CHAIN,
    A_EQUAL,
    A_DIGIT,
    A_INC,
    A_DEC
  } action_t;

  // latched item
  logic [ModeW-1:0] mode_r;
  logic [KeyW-1:0]  key_r;

  // calculator state
  phase_t          phase_r, phase_nxt;
  logic [W-1:0]    first_r, first_nxt;
  logic [W-1:0]    second_r, second_nxt;
  op_t             opc_r, opc_nxt;
  logic [W-1:0]    result_r, result_nxt;

  // output register
  logic            ov_r;
  logic            o_clr_r, o_echo_r, o_rv_r, o_dz_r;
  logic [KeyW-1:0] o_char_r;
  logic [ResW-1:0] o_res_r;
  phase_t          o_phase_r;

  logic            clr_nxt, echo_nxt, rv_nxt, dz_nxt;
  logic [KeyW-1:0] char_nxt;
  logic [ResW-1:0] res_out;

  action_t         action;
  logic            key_is_op;
  op_t             key_op;
  logic            key_is_digit;
  logic [KeyW-1:0] digit_diff;
  logic [W-1:0]    acc_sel;
  logic [W-1:0]    times10;

  logic            alu_done, alu_dz;
  logic [W-1:0]    alu_res;

  always_comb begin
    key_is_op = 1'b1;
    key_op    = OP_ADD;
    case (key_r)
      KEY_PLUS:  key_op = OP_ADD;
      KEY_MINUS: key_op = OP_SUB;
      KEY_STAR:  key_op = OP_MUL;
      KEY_SLASH: key_op = OP_DIV;
      default:   key_is_op = 1'b0;
    endcase
  end

  assign key_is_digit = key_r inside {[KEY_ZERO:KEY_NINE]};
  assign digit_diff   = key_r - KEY_ZERO;

  always_comb begin
    action = A_NONE;
    if (mode_r == MODE_KEY) begin
      if (key_r == KEY_CLEAR) begin
        action = A_CLEAR;
      end else if (key_is_op && (phase_r == PH_FIRST || phase_r == PH_OPER)) begin
        action = A_SETOP;
      end else if (key_is_op && phase_r == PH_SECOND) begin
        action = A_CHAIN;
      end else if (key_r == KEY_EQUAL && phase_r == PH_SECOND) begin
        action = A_EQUAL;
      end else if (key_is_digit) begin
        action = A_DIGIT;
      end
    end else if (phase_r == PH_RESULT) begin
      if (mode_r == MODE_INC) begin
        action = A_INC;
      end else if (mode_r == MODE_DEC) begin
        action = A_DEC;
      end
    end
  end

  // one shared x*10+d for whichever operand is being built
  assign acc_sel = (phase_r == PH_SECOND) ? second_r : first_r;
  assign times10 = (acc_sel << 3) + (acc_sel << 1) + W'(digit_diff[3:0]);

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    opc_nxt    = opc_r;
    result_nxt = result_r;
    clr_nxt    = 1'b0;
    echo_nxt   = 1'b0;
    char_nxt   = '0;
    rv_nxt     = 1'b0;
    dz_nxt     = 1'b0;
    case (action)
      A_CLEAR: begin
        clr_nxt    = 1'b1;
        phase_nxt  = PH_FIRST;
        first_nxt  = '0;
        second_nxt = '0;
      end
      A_SETOP: begin
        clr_nxt   = 1'b1;
        opc_nxt   = key_op;
        echo_nxt  = 1'b1;
        char_nxt  = key_r;
        phase_nxt = PH_OPER;
      end
      A_CHAIN: begin
        clr_nxt    = 1'b1;
        result_nxt = alu_res;
        opc_nxt    = key_op;
        first_nxt  = alu_res;
        second_nxt = '0;
        rv_nxt     = 1'b1;
        dz_nxt     = alu_dz;
      end
      A_EQUAL: begin
        clr_nxt    = 1'b1;
        result_nxt = alu_res;
        phase_nxt  = PH_RESULT;
        rv_nxt     = 1'b1;
        dz_nxt     = alu_dz;
      end
      A_DIGIT: begin
        echo_nxt = 1'b1;
        char_nxt = key_r;
        case (phase_r)
          PH_FIRST: begin
            clr_nxt   = (first_r == '0);
            first_nxt = times10;
          end
          PH_SECOND: begin
            clr_nxt    = (second_r == '0);
            second_nxt = times10;
          end
          PH_RESULT: begin
            clr_nxt   = 1'b1;
            phase_nxt = PH_FIRST;
            first_nxt = W'(digit_diff[3:0]);
          end
          default: begin
            clr_nxt    = 1'b1;
            phase_nxt  = PH_SECOND;
            second_nxt = W'(digit_diff[3:0]);
          end
        endcase
      end
      A_INC: begin
        clr_nxt    = 1'b1;
        result_nxt = result_r + W'(1);
        rv_nxt     = 1'b1;
      end
      A_DEC: begin
        clr_nxt    = 1'b1;
        result_nxt = result_r - W'(1);
        rv_nxt     = 1'b1;
      end
      default: begin
        clr_nxt = 1'b0;
      end
    endcase
  end

  generate
    if (W >= ResW) begin : g_res_trunc
      assign res_out = result_nxt[ResW-1:0];
    end else begin : g_res_ext
      assign res_out = {{(ResW-W){1'b0}}, result_nxt};
    end
  endgenerate

  ffc_alu #(
    .W (W)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_arith),
    .op    (opc_r),
    .a     (first_r),
    .b     (second_r),
    .done  (alu_done),
    .res   (alu_res),
    .dz    (alu_dz)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      first_r  <= '0;
      second_r <= '0;
      opc_r    <= OP_ADD;
      result_r <= '0;
    end else if (cmd.commit) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      opc_r    <= opc_nxt;
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.commit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.commit) begin
      o_clr_r   <= clr_nxt;
      o_echo_r  <= echo_nxt;
      o_char_r  <= char_nxt;
      o_rv_r    <= rv_nxt;
      o_res_r   <= res_out;
      o_phase_r <= phase_nxt;
      o_dz_r    <= dz_nxt;
    end
  end

  assign stat.need_arith = (action == A_CHAIN) || (action == A_EQUAL);
  assign stat.arith_done = alu_done;
  assign stat.out_free   = !ov_r || out_ready;

  assign out_valid          = ov_r;
  assign out_display_clear  = o_clr_r;
  assign out_echo_valid     = o_echo_r;
  assign out_echo_char      = o_char_r;
  assign out_result_valid   = o_rv_r;
  assign out_result_value   = o_res_r;
  assign out_phase          = o_phase_r;
  assign out_divide_by_zero = o_dz_r;

endmodule

`default_nettype wire

// File: hw/rtl/ffc_ctrl.sv
// ----------------------------------------------------------------------------
// ffc_ctrl
// Calculator controller: accept an item, decode, run the arithmetic unit
// when needed, commit into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ffc_pkg::ffc_stat_t  stat,
  output ffc_pkg::ffc_cmd_t        cmd
);
  import ffc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_ARITH,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = stat.need_arith ? S_ARITH : S_COMMIT;
      end
      S_ARITH: begin
        if (stat.arith_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cmd.load_in     = (state_r == S_IDLE) && in_valid;
  assign cmd.start_arith = (state_r == S_DECODE) && stat.need_arith;
  assign cmd.commit      = (state_r == S_COMMIT) && stat.out_free;

endmodule

`default_nettype wire

// File: hw/rtl/four_function_calculator_fsm.sv
// ----------------------------------------------------------------------------
// four_function_calculator_fsm
// Four-function integer calculator driven by key codes and inc/dec buttons.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload
//   in_ch    sink       mode, key_code
//   out_ch   source     display_clear, echo_valid, echo_char, result_valid,
//                       result_value, phase, divide_by_zero
//
// one item in flight: accept, decode, commit; '=' or a chained operator also runs
// the arithmetic unit between decode and commit
// a pending '*' or '/' runs the one-bit-per-cycle loop, and a divide then fixes the
// sign; a division by zero skips the loop
// the output register holds a stalled item and the commit waits for it to drain
// synchronous active-low reset returns to the first-number phase, all zero
//
`default_nettype none

module four_function_calculator_fsm #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffc_in_if.sink     in_ch,
  ffc_out_if.source  out_ch
);
  import ffc_pkg::*;

  ffc_cmd_t  cmd;
  ffc_stat_t stat;

  ffc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffc_dp #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_ch.mode),
    .in_key             (in_ch.key_code),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_display_clear  (out_ch.display_clear),
    .out_echo_valid     (out_ch.echo_valid),
    .out_echo_char      (out_ch.echo_char),
    .out_result_valid   (out_ch.result_valid),
    .out_result_value   (out_ch.result_value),
    .out_phase          (out_ch.phase),
    .out_divide_by_zero (out_ch.divide_by_zero)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ffc_chk.sv
// ----------------------------------------------------------------------------
// ffc_chk
// Port-level checks of the calculator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic         display_clear,
  input wire logic         echo_valid,
  input wire logic [7:0]   echo_char,
  input wire logic         result_valid,
  input wire logic [31:0]  result_value,
  input wire logic [1:0]   phase,
  input wire logic         divide_by_zero
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(phase)
      && $stable(echo_char) && $stable(display_clear))
    else $error("stalled item changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_no_echo_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !echo_valid |-> echo_char == 8'h00)
    else $error("echo character without echo");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_valid |-> display_clear)
    else $error("result shown without display clear");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_by_zero |-> result_valid && result_value == 32'h0)
    else $error("divide by zero item malformed");

endmodule

bind four_function_calculator_fsm ffc_chk u_ffc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .display_clear  (out_ch.display_clear),
  .echo_valid     (out_ch.echo_valid),
  .echo_char      (out_ch.echo_char),
  .result_valid   (out_ch.result_valid),
  .result_value   (out_ch.result_value),
  .phase          (out_ch.phase),
  .divide_by_zero (out_ch.divide_by_zero)
);

`default_nettype wire
